FILE: hw/rtl/sia_pkg.sv
// Package for the signed integer ALU: data width, operation codes, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sia_pkg;
   localparam int DataWidth = 64;
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);
   localparam int MulPieces = 4;
   localparam int PieceW = DataWidth / MulPieces;

   typedef enum logic [3:0] {
      OP_NE  = 4'd3,
      OP_EQ  = 4'd4,
      OP_GT  = 4'd5,
      OP_LT  = 4'd6,
      OP_GE  = 4'd7,
      OP_LE  = 4'd8,
      OP_SUB = 4'd9,
      OP_ADD = 4'd10,
      OP_MOD = 4'd11,
      OP_DIV = 4'd12,
      OP_MUL = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      CLS_QUICK = 2'd0,
      CLS_MUL   = 2'd1,
      CLS_DIV   = 2'd2
   } class_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [63:0] left;
      logic [63:0] right;
      logic        prior_error;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic        error;
   } rsp_type;

   // item as classified by the front part
   typedef struct packed {
      class_type             cls;
      logic                  is_div;
      logic [DataWidth-1:0]  a;
      logic [DataWidth-1:0]  b;
      logic [DataWidth-1:0]  quick;
      logic                  err;
   } work_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } exec_state_type;

   function automatic logic [63:0] sext(input logic [DataWidth-1:0] x);
      sext = 64'($signed(x));
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/sia_front.sv
// Front part: fits operands, decodes the code, evaluates add/sub/compare.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sia_front import sia_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_item,
   input  wire logic    q_full,
   output logic         busy,
   output logic         q_push,
   output work_type     q_data
);
   logic [DataWidth-1:0] a, b, sum, dif;
   logic                 lt, gt, eq;
   work_type             w_in, w_ff;
   logic                 v_ff, v_in;

   assign a   = req_item.left[DataWidth-1:0];
   assign b   = req_item.right[DataWidth-1:0];
   assign sum = a + b;
   assign dif = a - b;
   assign lt  = $signed(a) < $signed(b);
   assign gt  = $signed(b) < $signed(a);
   assign eq  = a == b;

   always_comb begin
      w_in.a      = a;
      w_in.b      = b;
      w_in.err    = req_item.prior_error;
      w_in.is_div = req_item.operation == OP_DIV;
      w_in.cls    = CLS_QUICK;
      w_in.quick  = a;
      unique case (req_item.operation)
         OP_MUL: w_in.cls = CLS_MUL;
         OP_DIV, OP_MOD: begin
            w_in.cls = CLS_DIV;
            if (b == '0) begin
               w_in.cls = CLS_QUICK;
               w_in.err = 1'b1;
            end
         end
         OP_ADD: w_in.quick = sum;
         OP_SUB: w_in.quick = dif;
         OP_LE:  w_in.quick = DataWidth'(!gt);
         OP_GE:  w_in.quick = DataWidth'(!lt);
         OP_LT:  w_in.quick = DataWidth'(lt);
         OP_GT:  w_in.quick = DataWidth'(gt);
         OP_EQ:  w_in.quick = DataWidth'(eq);
         OP_NE:  w_in.quick = DataWidth'(!eq);
         default: w_in.quick = a;
      endcase
   end

   // one register stage; hold while the queue is full
   assign busy   = v_ff && q_full;
   assign q_push = v_ff && !q_full;
   assign q_data = w_ff;
   assign v_in   = (start && !busy) ? 1'b1 : (q_push ? 1'b0 : v_ff);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else       v_ff <= v_in;
      if (start && !busy) w_ff <= w_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/sia_queue.sv
// Short FIFO between the front and back parts.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sia_queue import sia_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output work_type      pop_data
);
   work_type         mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ff, rd_ff;
   logic [QPtrW:0]   cnt_ff;

   assign full      = cnt_ff == (QPtrW+1)'(QDepth);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (QPtrW+1)'(QDepth))
      else $error("queue count overflow");
endmodule
`default_nettype wire

FILE: hw/rtl/sia_back.sv
// Back part: multiplies in 16-bit pieces, divides one bit a cycle, emits results.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sia_back import sia_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire work_type q_data,
   output logic          q_pop,
   output logic          rsp_strobe,
   output rsp_type       rsp_item
);
   localparam int CntW = $clog2(DataWidth + 1);

   exec_state_type       state_ff, state_in;
   logic [DataWidth-1:0] a_ff, b_ff, acc_ff, rem_ff, quo_ff;
   logic [CntW-1:0]      cnt_ff;
   logic                 is_div_ff, neg_q_ff, neg_r_ff;
   logic [DataWidth-1:0] ma, mb, pp, acc_in, res;
   logic [DataWidth:0]   trial;
   logic [DataWidth-1:0] rem_sh;
   logic                 load;

   assign ma = q_data.a[DataWidth-1] ? -q_data.a : q_data.a;
   assign mb = q_data.b[DataWidth-1] ? -q_data.b : q_data.b;

   // one piece of the right operand per cycle, shifted into place
   assign pp     = DataWidth'(a_ff * b_ff[PieceW-1:0]);
   assign acc_in = acc_ff + (pp << (int'(cnt_ff) * PieceW));

   assign rem_sh = {rem_ff[DataWidth-2:0], a_ff[DataWidth-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, b_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_valid && q_data.cls == CLS_MUL) state_in = ST_MUL;
                  else if (q_valid && q_data.cls == CLS_DIV) state_in = ST_DIV;
         ST_MUL:  if (cnt_ff == CntW'(MulPieces - 1)) state_in = ST_DONE;
         ST_DIV:  if (cnt_ff == CntW'(DataWidth - 1)) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign load  = state_ff == ST_IDLE && q_valid;
   assign q_pop = load;

   always_comb begin
      res = is_div_ff ? (neg_q_ff ? -quo_ff : quo_ff) : (neg_r_ff ? -rem_ff : rem_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= (load && q_data.cls == CLS_QUICK) || state_ff == ST_DONE;
      end
      if (load) begin
         cnt_ff    <= '0;
         is_div_ff <= q_data.is_div;
         neg_q_ff  <= q_data.a[DataWidth-1] ^ q_data.b[DataWidth-1];
         neg_r_ff  <= q_data.a[DataWidth-1];
         acc_ff    <= '0;
         rem_ff    <= '0;
         quo_ff    <= '0;
         if (q_data.cls == CLS_DIV) begin
            a_ff <= ma;
            b_ff <= mb;
         end else begin
            a_ff <= q_data.a;
            b_ff <= q_data.b;
         end
         rsp_item.value <= sext(q_data.quick);
         // a real division always clears the flag
         rsp_item.error <= (q_data.cls == CLS_DIV) ? 1'b0 : q_data.err;
      end else if (state_ff == ST_MUL) begin
         acc_ff <= acc_in;
         b_ff   <= b_ff >> PieceW;
         cnt_ff <= cnt_ff + 1'b1;
      end else if (state_ff == ST_DIV) begin
         a_ff   <= a_ff << 1;
         cnt_ff <= cnt_ff + 1'b1;
         if (!trial[DataWidth]) begin
            rem_ff <= trial[DataWidth-1:0];
            quo_ff <= {quo_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DataWidth-2:0], 1'b0};
         end
      end else if (state_ff == ST_DONE) begin
         rsp_item.value <= sext(res);
      end
      if (state_ff == ST_MUL && state_in == ST_DONE) begin
         is_div_ff <= 1'b1;
         neg_q_ff  <= 1'b0;
         quo_ff    <= acc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_strobe)
      else $error("long item finished without a result");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("queue popped while unit busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> cnt_ff < CntW'(MulPieces))
      else $error("multiply step count overrun");
endmodule
`default_nettype wire

FILE: hw/rtl/signed_integer_alu_core.sv
// Top level of the signed integer ALU: front, queue, back.
// Depends on sia_pkg, sia_front, sia_queue, sia_back.
//
//   channel  ports                           handshake
//   request  start, busy, req_item           taken when start && !busy
//   result   rsp_strobe, rsp_item            one cycle, no backpressure
//
// Add, subtract, compare, unknown codes, zero divisors: front register, queue,
// back result register; one item per cycle while no long item holds the back
// part. Multiply forms four 16x64 partial products; divide and remainder
// give one quotient bit a cycle. The back part runs one long item at a time;
// busy rises when the 4-entry queue and the front register are full. Reset
// is synchronous and clears all control state; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module signed_integer_alu_core import sia_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);
   logic     q_push, q_full, q_pop, q_valid;
   work_type q_in, q_out;

   sia_front u_front (
      .clock, .reset, .start, .req_item, .q_full,
      .busy, .q_push, .q_data(q_in)
   );

   sia_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
   );

   sia_back u_back (
      .clock, .reset, .q_valid, .q_data(q_out), .q_pop,
      .rsp_strobe, .rsp_item
   );
endmodule
`default_nettype wire
